[design/aqs_pkg.sv]
package aqs_pkg;

  localparam int MAX_ITEMS_DEF  = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_POP,
    ST_POP_WAIT,
    ST_PIV_WAIT,
    ST_J_READ,
    ST_J_CHK,
    ST_I_READ,
    ST_I_CHK,
    ST_SWAP1,
    ST_SWAP2,
    ST_FIN_READ,
    ST_FIN_WAIT,
    ST_FIN_WR,
    ST_EMIT_RD,
    ST_EMIT_WAIT
  } aqs_state_t;

endpackage

[design/array_sorter_quicksort_unit.sv]
// Quicksort sorter. Words arrive on the slave side, one per cycle, and fill an
// element RAM until a word with tlast arrives (that word belongs to the set).
// The set is then sorted in place by quicksort (first element as pivot, two
// indices closing in, pending sub-ranges on a stack RAM), and the sorted words
// leave on the master side in ascending signed order, tlast on the largest.
// Words beyond MAX_ITEMS are dropped and tuser is set on every result of that
// set. Sorting has one read port on the element RAM with a registered read,
// so each compare step first reads a word and then checks it against the
// pivot; a swap writes both words back, and each partition ends by moving
// the split element to the range head, writing the pivot and pushing the
// sub-ranges. Each result is read from the element RAM before it is handed
// out. No new set is taken while a set is being sorted or emitted.
module array_sorter_quicksort_unit
  import aqs_pkg::*;
#(
  parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [VALUE_W-1:0] s_tdata,  // [31:0] value
  input  logic               s_tlast,  // last
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [VALUE_W-1:0] m_tdata,  // [31:0] sorted_value
  output logic               m_tlast,  // end_of_set
  output logic               m_tuser   // [0] overflowed
);

  localparam int EW = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int SW = 2 * AW;

  aqs_state_t state, state_next;

  logic [CW-1:0] item_count;
  logic          drop_flag;
  logic [CW-1:0] stack_ptr;
  logic [AW-1:0] lo_idx, hi_idx, i_idx, j_idx;
  logic signed [EW-1:0] pivot, a_i, a_j;
  logic [CW-1:0] emit_cnt;

  logic                 e_we;
  logic [AW-1:0]        e_waddr, e_raddr;
  logic signed [EW-1:0] e_wdata, e_rdata;
  logic                 st_we;
  logic [AW-1:0]        st_waddr, st_raddr;
  logic [SW-1:0]        st_wdata, st_rdata;

  logic          in_acc;
  logic          load_out;
  logic          room;
  logic [AW-1:0] pop_lo, pop_hi;

  assign s_tready = (state == ST_LOAD);
  assign in_acc   = s_tvalid && s_tready;
  assign room     = (item_count < CW'(MAX_ITEMS));
  assign pop_lo   = st_rdata[AW-1:0];
  assign pop_hi   = st_rdata[SW-1:AW];

  aqs_ram #(.WIDTH(EW), .DEPTH(MAX_ITEMS)) u_elem_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  aqs_ram #(.WIDTH(SW), .DEPTH(MAX_ITEMS)) u_stack_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    e_we       = 1'b0;
    e_waddr    = i_idx;
    e_wdata    = a_j;
    e_raddr    = i_idx;
    st_we      = 1'b0;
    st_waddr   = stack_ptr[AW-1:0];
    st_wdata   = {hi_idx, lo_idx};
    st_raddr   = AW'(stack_ptr - CW'(1));
    load_out   = 1'b0;
    unique case (state)
      ST_LOAD: begin
        e_waddr = item_count[AW-1:0];
        e_wdata = s_tdata[EW-1:0];
        e_we    = in_acc && room;
        if (in_acc && s_tlast) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        st_waddr = '0;
        st_wdata = {AW'(item_count - CW'(1)), AW'(0)};
        if (item_count < CW'(2)) begin
          state_next = ST_EMIT_RD;
        end else begin
          st_we      = 1'b1;
          state_next = ST_POP;
        end
      end
      ST_POP: begin
        if (stack_ptr == '0) begin
          state_next = ST_EMIT_RD;
        end else begin
          state_next = ST_POP_WAIT;
        end
      end
      ST_POP_WAIT: begin
        e_raddr = pop_lo;
        if (pop_lo >= pop_hi) begin
          state_next = ST_POP;
        end else begin
          state_next = ST_PIV_WAIT;
        end
      end
      ST_PIV_WAIT: begin
        state_next = ST_J_READ;
      end
      ST_J_READ: begin
        e_raddr = j_idx;
        if (i_idx < j_idx) begin
          state_next = ST_J_CHK;
        end else begin
          state_next = ST_FIN_READ;
        end
      end
      ST_J_CHK: begin
        e_raddr = j_idx;
        if (e_rdata >= pivot) begin
          state_next = ST_J_READ;
        end else begin
          state_next = ST_I_READ;
        end
      end
      ST_I_READ: begin
        if (i_idx < j_idx) begin
          state_next = ST_I_CHK;
        end else begin
          state_next = ST_FIN_READ;
        end
      end
      ST_I_CHK: begin
        if (e_rdata <= pivot) begin
          state_next = ST_I_READ;
        end else begin
          state_next = ST_SWAP1;
        end
      end
      ST_SWAP1: begin
        e_we       = 1'b1;
        state_next = ST_SWAP2;
      end
      ST_SWAP2: begin
        e_we       = 1'b1;
        e_waddr    = j_idx;
        e_wdata    = a_i;
        state_next = ST_J_READ;
      end
      ST_FIN_READ: begin
        state_next = ST_FIN_WAIT;
      end
      ST_FIN_WAIT: begin
        // element at the split point goes to the range head; push left part
        e_we       = 1'b1;
        e_waddr    = lo_idx;
        e_wdata    = e_rdata;
        st_wdata   = {AW'(i_idx - AW'(1)), lo_idx};
        st_we      = (i_idx > lo_idx) && (stack_ptr < CW'(MAX_ITEMS));
        state_next = ST_FIN_WR;
      end
      ST_FIN_WR: begin
        e_we       = 1'b1;
        e_wdata    = pivot;
        st_wdata   = {hi_idx, AW'(i_idx + AW'(1))};
        st_we      = (i_idx < hi_idx) && (stack_ptr < CW'(MAX_ITEMS));
        state_next = ST_POP;
      end
      ST_EMIT_RD: begin
        e_raddr    = emit_cnt[AW-1:0];
        state_next = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        // hold the read address so the word stays on the RAM output
        e_raddr = emit_cnt[AW-1:0];
        if (!m_tvalid || m_tready) begin
          load_out = 1'b1;
          if ((emit_cnt + CW'(1)) == item_count) begin
            state_next = ST_LOAD;
          end else begin
            state_next = ST_EMIT_RD;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= '0;
      drop_flag  <= 1'b0;
      stack_ptr  <= '0;
      emit_cnt   <= '0;
    end else begin
      if (in_acc) begin
        if (room) begin
          item_count <= item_count + CW'(1);
        end else begin
          drop_flag <= 1'b1;
        end
      end
      if (state == ST_POP && stack_ptr != '0) begin
        stack_ptr <= stack_ptr - CW'(1);
      end else if (st_we) begin
        stack_ptr <= stack_ptr + CW'(1);
      end
      if (state == ST_START || state == ST_POP) begin
        emit_cnt <= '0;
      end else if (load_out) begin
        emit_cnt <= emit_cnt + CW'(1);
        if ((emit_cnt + CW'(1)) == item_count) begin
          item_count <= '0;
          drop_flag  <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_idx <= '0;
      hi_idx <= '0;
      i_idx  <= '0;
      j_idx  <= '0;
      pivot  <= '0;
    end else begin
      case (state)
        ST_POP_WAIT: begin
          lo_idx <= pop_lo;
          hi_idx <= pop_hi;
          i_idx  <= pop_lo;
          j_idx  <= pop_hi;
        end
        ST_PIV_WAIT: pivot <= e_rdata;
        ST_J_CHK: begin
          if (e_rdata >= pivot) begin
            j_idx <= j_idx - AW'(1);
          end else begin
            a_j <= e_rdata;
          end
        end
        ST_I_CHK: begin
          if (e_rdata <= pivot) begin
            i_idx <= i_idx + AW'(1);
          end else begin
            a_i <= e_rdata;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= VALUE_W'(e_rdata);
      m_tlast <= ((emit_cnt + CW'(1)) == item_count);
      m_tuser <= drop_flag;
    end
  end

`ifndef SYNTHESIS
  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_J_CHK || state == ST_I_CHK) |-> (i_idx < j_idx))
    else $error("partition index crossed during compare");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_ptr <= item_count)
    else $error("more pending ranges than elements");

  a_swap_side: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWAP1) |-> (a_j < pivot && a_i > pivot))
    else $error("swap of elements on the correct side of the pivot");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (load_out && m_tvalid) |-> m_tready)
    else $error("result overwritten before it was taken");
`endif

endmodule

[design/aqs_ram.sv]
module aqs_ram
  import aqs_pkg::*;
#(
  parameter int WIDTH = DATA_WIDTH_DEF,
  parameter int DEPTH = MAX_ITEMS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top
  import aqs_pkg::*;
;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_WAIT  = 64;
  localparam int ITEM_TARGET = 450;
  localparam int QUIET_AFTER = 380;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               eos;
    logic               ovf;
  } sorted_word_t;

  typedef enum int {
    FILL_RANDOM,
    FILL_ASCEND,
    FILL_DESCEND,
    FILL_FEW,
    FILL_NARROW
  } fill_shape_t;

  // Collects each set as the block would hold it and queues its sorted words.
  class sort_scoreboard;
    int           held[$];
    bit           dropped;
    sorted_word_t sorted_due[$];
    int           errors;
    int           sets;
    int           over_sets;
    int           largest;
    int           checked;

    function int pending();
      return sorted_due.size();
    endfunction

    task report(string what);
      $display("tb_top: mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    function void take_word(logic [VALUE_W-1:0] v, logic last);
      int           key;
      int           b;
      int           n;
      sorted_word_t w;
      if (held.size() < MAX_ITEMS_DEF) held.push_back(int'(v));
      else dropped = 1'b1;
      if (!last) return;
      n = held.size();
      // insertion sort on signed values; equal words are indistinguishable
      for (int a = 1; a < n; a++) begin
        key = held[a];
        b = a - 1;
        while (b >= 0 && held[b] > key) begin
          held[b+1] = held[b];
          b--;
        end
        held[b+1] = key;
      end
      for (int k = 0; k < n; k++) begin
        w.value = held[k];
        w.eos   = (k == n - 1);
        w.ovf   = dropped;
        sorted_due.push_back(w);
      end
      sets++;
      if (dropped) over_sets++;
      if (n > largest) largest = n;
      held.delete();
      dropped = 1'b0;
    endfunction

    task check_word(logic [VALUE_W-1:0] v, logic eos, logic ovf);
      sorted_word_t w;
      if (sorted_due.size() == 0) begin
        report($sformatf("unexpected word %0d", $signed(v)));
        return;
      end
      w = sorted_due.pop_front();
      checked++;
      if (v !== w.value)
        report($sformatf("value %0d, want %0d", $signed(v), $signed(w.value)));
      if (eos !== w.eos)
        report($sformatf("tlast %b, want %b on %0d", eos, w.eos, $signed(w.value)));
      if (ovf !== w.ovf)
        report($sformatf("tuser %b, want %b on %0d", ovf, w.ovf, $signed(w.value)));
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [VALUE_W-1:0] s_tdata;   // [31:0] value
  logic               s_tlast;   // last
  logic               m_tvalid;
  logic               m_tready;
  logic [VALUE_W-1:0] m_tdata;   // [31:0] sorted_value
  logic               m_tlast;   // end_of_set
  logic               m_tuser;   // [0] overflowed

  sort_scoreboard sb;
  int  words_sent;
  int  words_in;
  int  quiet_cycles;
  int  long_hold;
  bit  quiet;

  array_sorter_quicksort_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Sample both sides at the rising edge; watch for a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.take_word(s_tdata, s_tlast);
        words_in++;
      end
      if (m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast, m_tuser);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_top: no word moved for %0d cycles", STALL_LIMIT);
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // Sink: random stall bursts, plus one long hold-off on request, counted
  // only while a word is waiting.
  initial begin
    int gap;
    gap = 0;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold > 0) begin
        if (m_tvalid) long_hold--;
        m_tready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        gap = $urandom_range(1, 6) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
      @(negedge clk);
    end
  end

  // Starts and ends at a falling edge; holds the word until accepted.
  task automatic send_word(input logic [VALUE_W-1:0] v, input logic last);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    words_sent++;
    if (words_sent >= QUIET_AFTER) quiet = 1'b1;
  endtask

  function automatic logic [VALUE_W-1:0] fill_value(fill_shape_t shape, int k, int base);
    logic [VALUE_W-1:0] few [6];
    few = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h5};
    case (shape)
      FILL_ASCEND:  return base + k * 37;
      FILL_DESCEND: return base - k * 37;
      FILL_FEW:     return few[$urandom_range(0, 5)];
      FILL_NARROW:  return $urandom_range(0, 16) - 8;
      default:      return $urandom;
    endcase
  endfunction

  task automatic send_set(input int n, input fill_shape_t shape);
    int base;
    base = int'($urandom_range(0, 2000)) - 1000;
    for (int k = 0; k < n; k++) send_word(fill_value(shape, k, base), k == n - 1);
  endtask

  task automatic send_list(input logic [VALUE_W-1:0] vals[$]);
    for (int k = 0; k < vals.size(); k++) send_word(vals[k], k == vals.size() - 1);
  endtask

  initial begin
    int          n;
    int          pick;
    fill_shape_t shape;
    bit          paused;
    sb = new();
    words_sent = 0;
    words_in = 0;
    quiet_cycles = 0;
    long_hold = 0;
    quiet = 1'b0;
    paused = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: single word, extremes, duplicates, reversed order
    send_list('{32'h7FFF_FFFF});
    send_list('{32'h7FFF_FFFF, 32'h8000_0000});
    send_list('{32'hFFFF_FFFF, 32'h0, 32'h1, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h5});
    send_list('{32'h3, 32'h3});
    send_set(6, FILL_DESCEND);

    // over capacity: words past the store limit are dropped, the last among them
    send_set(66, FILL_RANDOM);
    // presorted full store is the deepest partition case; stall the sink meanwhile
    long_hold = LONG_HOLD;
    send_set(MAX_ITEMS_DEF, FILL_ASCEND);

    while (words_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 29);
      if (pick < 3) n = $urandom_range(65, 70);
      else if (pick < 6) n = $urandom_range(40, MAX_ITEMS_DEF);
      else n = $urandom_range(1, 12);
      shape = fill_shape_t'($urandom_range(0, 4));
      send_set(n, shape);
      // drain completely once, mid-run
      if (!paused && words_sent > ITEM_TARGET / 2) begin
        paused = 1'b1;
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
      end
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("tb_top: %0d sets from %0d input words, %0d sorted words checked",
             sb.sets, words_in, sb.checked);
    $display("tb_top: %0d sets over capacity, largest set %0d, long sink hold and drain pause",
             sb.over_sets, sb.largest);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: %0d mismatches, %0d words still due", sb.errors, sb.pending());
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
